@@ hdl/bf_instruction_executor_core_defines.svh @@
// assertion macros used by the port-level checker
`ifndef BF_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define BF_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define BFX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bfx_pkg.sv @@
// shared types and constants of the instruction executor
package bfx_pkg;

    localparam int POS_W  = 16;
    localparam int SKIP_W = 16;

    localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RIGHT,
        OP_LEFT,
        OP_INC,
        OP_DEC,
        OP_OUT,
        OP_IN,
        OP_OPEN,
        OP_CLOSE,
        OP_EOP
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_HALT      = 3'd1,
        ST_UNMATCHED = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_UNDERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [7:0]       in_char;
    } item_t;

endpackage

@@ hdl/bfx_ram.sv @@
// generic simple dual-port ram with registered read
module bfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bfx_front.sv @@
// front end: accepts requests, decodes the command and queues it
module bfx_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           hold,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfx_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [bfx_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           q_valid,
    input  logic                           q_ready,
    output bfx_pkg::item_t                 q_item
);

    localparam int QDEPTH = 2;

    bfx_pkg::item_t  q_mem_reg [QDEPTH];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;
    bfx_pkg::op_t    dec_op;
    bfx_pkg::item_t  new_item;

    always_comb
    begin
        if (s_tuser[0])
        begin
            dec_op = bfx_pkg::OP_EOP;
        end
        else
        begin
            unique case (s_tdata[7:0])
                bfx_pkg::CH_RIGHT: dec_op = bfx_pkg::OP_RIGHT;
                bfx_pkg::CH_LEFT:  dec_op = bfx_pkg::OP_LEFT;
                bfx_pkg::CH_INC:   dec_op = bfx_pkg::OP_INC;
                bfx_pkg::CH_DEC:   dec_op = bfx_pkg::OP_DEC;
                bfx_pkg::CH_OUT:   dec_op = bfx_pkg::OP_OUT;
                bfx_pkg::CH_IN:    dec_op = bfx_pkg::OP_IN;
                bfx_pkg::CH_OPEN:  dec_op = bfx_pkg::OP_OPEN;
                bfx_pkg::CH_CLOSE: dec_op = bfx_pkg::OP_CLOSE;
                default:           dec_op = bfx_pkg::OP_NOP;
            endcase
        end
    end

    assign new_item.op      = dec_op;
    assign new_item.pos     = s_tdata[23:8];
    assign new_item.in_char = s_tdata[31:24];

    assign s_tready = !hold && (count_reg != 2'(QDEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ hdl/bfx_back.sv @@
// back end: executes queued commands against the tape and the loop stack
module bfx_back #(
    parameter int TAPE_CELLS = 4096,
    parameter int LOOP_DEPTH = 16,
    parameter int POS_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  bfx_pkg::item_t                 q_item,
    output logic                           busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bfx_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [bfx_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int PTR_BITS = $clog2(TAPE_CELLS);
    localparam int STK_BITS = $clog2(LOOP_DEPTH);
    localparam int CNT_BITS = $clog2(LOOP_DEPTH + 1);
    localparam int SW = (POS_BITS < bfx_pkg::POS_W) ? POS_BITS : bfx_pkg::POS_W;
    localparam logic [PTR_BITS-1:0] LAST_CELL  = PTR_BITS'(TAPE_CELLS - 1);
    localparam logic [CNT_BITS-1:0] DEPTH_FULL = CNT_BITS'(LOOP_DEPTH);

    // three-cell window around the pointer; side cells may still sit in the ram output
    logic [PTR_BITS-1:0]          dp_reg, dp_next;
    logic [7:0]                   lft_reg, lft_next, cur_reg, cur_next, rgt_reg, rgt_next;
    logic                         lft_pend_reg, lft_pend_next, rgt_pend_reg, rgt_pend_next;
    logic [7:0]                   lft_eff, rgt_eff;
    logic [PTR_BITS-1:0]          dp_p1, dp_p2, dp_m1, dp_m2;

    logic [SW-1:0]                top_reg, top_next, below_reg, below_next, below_eff;
    logic                         below_pend_reg, below_pend_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next, cnt_m3;
    logic [SW-1:0]                pos_inc;

    logic                         skipping_reg, skipping_next;
    logic [bfx_pkg::SKIP_W-1:0]   skip_depth_reg, skip_depth_next;
    logic                         halted_reg, halted_next;

    logic                         clearing_reg, clearing_next;
    logic [PTR_BITS-1:0]          clr_addr_reg, clr_addr_next;

    logic                         m_valid_reg, m_valid_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_char_reg, out_char_next;
    logic                         jump_valid_reg, jump_valid_next;
    logic [bfx_pkg::POS_W-1:0]    jump_target_reg, jump_target_next;
    bfx_pkg::status_t             status_reg, status_next;

    logic                         exec;
    logic                         tape_we, tape_re;
    logic [PTR_BITS-1:0]          tape_waddr, tape_raddr;
    logic [7:0]                   tape_wdata, tape_rdata;
    logic                         stk_we, stk_re;
    logic [SW-1:0]                stk_rdata;

    bfx_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .re    (tape_re),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    bfx_ram #(.WIDTH(SW), .DEPTH(LOOP_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (cnt_reg[STK_BITS-1:0]),
        .wdata (pos_inc),
        .re    (stk_re),
        .raddr (cnt_m3[STK_BITS-1:0]),
        .rdata (stk_rdata)
    );

    assign lft_eff   = lft_pend_reg ? tape_rdata : lft_reg;
    assign rgt_eff   = rgt_pend_reg ? tape_rdata : rgt_reg;
    assign below_eff = below_pend_reg ? stk_rdata : below_reg;

    assign dp_p1 = (dp_reg == LAST_CELL) ? '0 : dp_reg + PTR_BITS'(1);
    assign dp_p2 = (dp_p1 == LAST_CELL) ? '0 : dp_p1 + PTR_BITS'(1);
    assign dp_m1 = (dp_reg == '0) ? LAST_CELL : dp_reg - PTR_BITS'(1);
    assign dp_m2 = (dp_m1 == '0) ? LAST_CELL : dp_m1 - PTR_BITS'(1);

    assign cnt_m3  = cnt_reg - CNT_BITS'(3);
    assign pos_inc = q_item.pos[SW-1:0] + SW'(1);

    assign exec    = q_valid && !clearing_reg && (!m_valid_reg || m_tready);
    assign q_ready = exec;
    assign busy    = clearing_reg;

    always_comb
    begin
        dp_next          = dp_reg;
        lft_next         = lft_eff;
        cur_next         = cur_reg;
        rgt_next         = rgt_eff;
        lft_pend_next    = 1'b0;
        rgt_pend_next    = 1'b0;
        top_next         = top_reg;
        below_next       = below_eff;
        below_pend_next  = 1'b0;
        cnt_next         = cnt_reg;
        skipping_next    = skipping_reg;
        skip_depth_next  = skip_depth_reg;
        halted_next      = halted_reg;
        clearing_next    = clearing_reg;
        clr_addr_next    = clr_addr_reg;
        tape_we          = 1'b0;
        tape_waddr       = dp_m1;
        tape_wdata       = lft_eff;
        tape_re          = 1'b0;
        tape_raddr       = dp_p2;
        stk_we           = 1'b0;
        stk_re           = 1'b0;
        m_valid_next     = m_tready ? 1'b0 : m_valid_reg;
        out_valid_next   = out_valid_reg;
        out_char_next    = out_char_reg;
        jump_valid_next  = jump_valid_reg;
        jump_target_next = jump_target_reg;
        status_next      = status_reg;

        if (clearing_reg)
        begin
            tape_we       = 1'b1;
            tape_waddr    = clr_addr_reg;
            tape_wdata    = 8'd0;
            clr_addr_next = clr_addr_reg + PTR_BITS'(1);
            clearing_next = (clr_addr_reg != LAST_CELL);
        end

        if (exec)
        begin
            m_valid_next     = 1'b1;
            out_valid_next   = 1'b0;
            out_char_next    = 8'd0;
            jump_valid_next  = 1'b0;
            jump_target_next = '0;
            status_next      = bfx_pkg::ST_OK;

            if (halted_reg)
            begin
                status_next = bfx_pkg::ST_HALT;
            end
            else if (q_item.op == bfx_pkg::OP_EOP)
            begin
                status_next = skipping_reg ? bfx_pkg::ST_UNMATCHED : bfx_pkg::ST_HALT;
                halted_next = 1'b1;
            end
            else if (skipping_reg)
            begin
                // nesting count only; nothing else takes effect
                if (q_item.op == bfx_pkg::OP_OPEN)
                begin
                    if (skip_depth_reg != bfx_pkg::SKIP_MAX)
                    begin
                        skip_depth_next = skip_depth_reg + bfx_pkg::SKIP_W'(1);
                    end
                end
                else if (q_item.op == bfx_pkg::OP_CLOSE)
                begin
                    if (skip_depth_reg == '0)
                    begin
                        skipping_next = 1'b0;
                    end
                    else
                    begin
                        skip_depth_next = skip_depth_reg - bfx_pkg::SKIP_W'(1);
                    end
                end
            end
            else
            begin
                unique case (q_item.op)
                    bfx_pkg::OP_RIGHT:
                    begin
                        // left cell leaves the window, fetch the new right one
                        dp_next       = dp_p1;
                        lft_next      = cur_reg;
                        cur_next      = rgt_eff;
                        rgt_pend_next = 1'b1;
                        tape_we       = 1'b1;
                        tape_waddr    = dp_m1;
                        tape_wdata    = lft_eff;
                        tape_re       = 1'b1;
                        tape_raddr    = dp_p2;
                    end
                    bfx_pkg::OP_LEFT:
                    begin
                        dp_next       = dp_m1;
                        rgt_next      = cur_reg;
                        cur_next      = lft_eff;
                        lft_pend_next = 1'b1;
                        tape_we       = 1'b1;
                        tape_waddr    = dp_p1;
                        tape_wdata    = rgt_eff;
                        tape_re       = 1'b1;
                        tape_raddr    = dp_m2;
                    end
                    bfx_pkg::OP_INC:
                    begin
                        cur_next = cur_reg + 8'd1;
                    end
                    bfx_pkg::OP_DEC:
                    begin
                        cur_next = cur_reg - 8'd1;
                    end
                    bfx_pkg::OP_OUT:
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = cur_reg;
                    end
                    bfx_pkg::OP_IN:
                    begin
                        cur_next = q_item.in_char;
                    end
                    bfx_pkg::OP_OPEN:
                    begin
                        if (cur_reg == 8'd0)
                        begin
                            skipping_next   = 1'b1;
                            skip_depth_next = '0;
                        end
                        else if (cnt_reg >= DEPTH_FULL)
                        begin
                            status_next = bfx_pkg::ST_OVERFLOW;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            stk_we     = 1'b1;
                            below_next = top_reg;
                            top_next   = pos_inc;
                            cnt_next   = cnt_reg + CNT_BITS'(1);
                        end
                    end
                    bfx_pkg::OP_CLOSE:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = bfx_pkg::ST_UNDERFLOW;
                            halted_next = 1'b1;
                        end
                        else if (cur_reg == 8'd0)
                        begin
                            // pop: entry below top moves up, fetch the one beneath it
                            top_next        = below_eff;
                            below_pend_next = 1'b1;
                            stk_re          = 1'b1;
                            cnt_next        = cnt_reg - CNT_BITS'(1);
                        end
                        else
                        begin
                            jump_valid_next  = 1'b1;
                            jump_target_next = bfx_pkg::POS_W'(top_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg          <= '0;
            lft_reg         <= 8'd0;
            cur_reg         <= 8'd0;
            rgt_reg         <= 8'd0;
            lft_pend_reg    <= 1'b0;
            rgt_pend_reg    <= 1'b0;
            below_pend_reg  <= 1'b0;
            cnt_reg         <= '0;
            skipping_reg    <= 1'b0;
            skip_depth_reg  <= '0;
            halted_reg      <= 1'b0;
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            dp_reg          <= dp_next;
            lft_reg         <= lft_next;
            cur_reg         <= cur_next;
            rgt_reg         <= rgt_next;
            lft_pend_reg    <= lft_pend_next;
            rgt_pend_reg    <= rgt_pend_next;
            below_pend_reg  <= below_pend_next;
            cnt_reg         <= cnt_next;
            skipping_reg    <= skipping_next;
            skip_depth_reg  <= skip_depth_next;
            halted_reg      <= halted_next;
            clearing_reg    <= clearing_next;
            clr_addr_reg    <= clr_addr_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg         <= top_next;
        below_reg       <= below_next;
        out_valid_reg   <= out_valid_next;
        out_char_reg    <= out_char_next;
        jump_valid_reg  <= jump_valid_next;
        jump_target_reg <= jump_target_next;
        status_reg      <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, status_reg, jump_target_reg, out_char_reg};
    assign m_tuser  = {jump_valid_reg, out_valid_reg};

endmodule

@@ hdl/bf_instruction_executor_core.sv @@
// top level of the brainfuck instruction executor
// Executes one program character per request against an 8-bit tape of TAPE_CELLS
// cells and a loop stack of LOOP_DEPTH entries. After reset the tape is zeroed by a
// clearing pass, during which s_tready stays low. After that the block takes one
// request per cycle unless back-pressure or a full queue holds it: the front
// decodes it into a two-entry queue and the back executes it against a three-cell
// register window around the data pointer, with one tape ram read and one write per
// cycle, and registers its result. Each request gives exactly one result; a jump
// result asks the fetch side to resume at jump_target. Once a halting status has
// been returned, every further request answers with status halted until reset.
module bf_instruction_executor_core #(
    parameter int TAPE_CELLS = 4096,
    parameter int LOOP_DEPTH = 16,
    parameter int POS_BITS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // instr_byte[7:0], instr_pos[23:8], in_char[31:24]
    input  logic [bfx_pkg::S_TDATA_W-1:0]  s_tdata,
    // end_of_program[0]
    input  logic [bfx_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_char[7:0], jump_target[23:8], status[26:24], zero fill[31:27]
    output logic [bfx_pkg::M_TDATA_W-1:0]  m_tdata,
    // out_valid[0], jump_valid[1]
    output logic [bfx_pkg::M_TUSER_W-1:0]  m_tuser
);

    logic            q_valid;
    logic            q_ready;
    bfx_pkg::item_t  q_item;
    logic            busy;

    bfx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (busy),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    bfx_back #(
        .TAPE_CELLS (TAPE_CELLS),
        .LOOP_DEPTH (LOOP_DEPTH),
        .POS_BITS   (POS_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .busy     (busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ hdl/bfx_checker.sv @@
// port-level checker for the instruction executor and its bind
`include "bf_instruction_executor_core_defines.svh"

module bfx_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [bfx_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [bfx_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bfx_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [bfx_pkg::M_TUSER_W-1:0]  m_tuser
);

    logic       halt_seen_reg;
    logic [2:0] status;
    logic       in_unused;

    assign status    = m_tdata[26:24];
    assign in_unused = s_tvalid & s_tready & (^s_tdata) & s_tuser[0];

    // set once a halting status has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && (status != bfx_pkg::ST_OK) && !in_unused)
        begin
            halt_seen_reg <= 1'b1;
        end
        else if (m_tvalid && m_tready && (status != bfx_pkg::ST_OK))
        begin
            halt_seen_reg <= 1'b1;
        end
    end

    `BFX_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `BFX_ASSERT_ALWAYS(a_one_kind, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "output and jump in one result")
    `BFX_ASSERT_ALWAYS(a_jump_ok, (m_tvalid && m_tuser[1]) |-> (status == bfx_pkg::ST_OK), "jump with error status")
    `BFX_ASSERT_ALWAYS(a_idle_zero, m_tvalid |-> ((m_tuser[0] || (m_tdata[7:0] == 8'd0)) && (m_tuser[1] || (m_tdata[23:8] == 16'd0))), "unused result field not zero")
    `BFX_ASSERT_ALWAYS(a_stay_halted, (m_tvalid && halt_seen_reg) |-> ((status == bfx_pkg::ST_HALT) && (m_tuser == 2'd0) && (m_tdata[23:0] == 24'd0)), "activity after halt")

endmodule

bind bf_instruction_executor_core bfx_checker u_bfx_checker (.*);

@@ verif/bfx_result_checker.sv @@
// result checker: predicts each result of the instruction executor and compares it
module bfx_result_checker #(
    parameter int TAPE_CELLS = 4096,
    parameter int LOOP_DEPTH = 16,
    parameter int POS_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // instr_byte[7:0], instr_pos[23:8], in_char[31:24]
    input  logic [bfx_pkg::S_TDATA_W-1:0] s_tdata,
    // end_of_program[0]
    input  logic [bfx_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // out_char[7:0], jump_target[23:8], status[26:24], zero fill[31:27]
    input  logic [bfx_pkg::M_TDATA_W-1:0] m_tdata,
    // out_valid[0], jump_valid[1]
    input  logic [bfx_pkg::M_TUSER_W-1:0] m_tuser,
    output int                            fails,
    output int                            backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      out_valid;
        logic [7:0]                out_char;
        logic                      jump_valid;
        logic [bfx_pkg::POS_W-1:0] jump_target;
        bfx_pkg::status_t          status;
    } answer_t;

    localparam logic [31:0] POS_MASK =
        (POS_BITS >= 32) ? 32'hFFFF_FFFF : (32'd1 << POS_BITS) - 32'd1;

    logic [7:0]                 tape [TAPE_CELLS];
    int unsigned                cursor;
    logic [bfx_pkg::POS_W-1:0]  loop_heads [LOOP_DEPTH];
    int unsigned                loops_open;
    bit                         skipping;
    logic [bfx_pkg::SKIP_W-1:0] skip_nest;
    bit                         halted;
    answer_t                    due_answers [$];

    function automatic answer_t run_char(input logic [7:0] ch, input logic [31:0] pos,
                                         input logic [7:0] arg, input logic eop);
        answer_t a;
        a = '0;
        a.status = bfx_pkg::ST_OK;
        if (halted)
        begin
            a.status = bfx_pkg::ST_HALT;
        end
        else if (eop)
        begin
            a.status = skipping ? bfx_pkg::ST_UNMATCHED : bfx_pkg::ST_HALT;
            halted = 1'b1;
        end
        else if (skipping)
        begin
            // only brackets matter while a loop body is skipped
            if (ch == bfx_pkg::CH_OPEN)
            begin
                if (skip_nest != bfx_pkg::SKIP_MAX)
                    skip_nest = skip_nest + 1'b1;
            end
            else if (ch == bfx_pkg::CH_CLOSE)
            begin
                if (skip_nest == '0)
                    skipping = 1'b0;
                else
                    skip_nest = skip_nest - 1'b1;
            end
        end
        else
        begin
            case (ch)
                bfx_pkg::CH_RIGHT: cursor = (cursor == TAPE_CELLS - 1) ? 0 : cursor + 1;
                bfx_pkg::CH_LEFT:  cursor = (cursor == 0) ? TAPE_CELLS - 1 : cursor - 1;
                bfx_pkg::CH_INC:   tape[cursor] = tape[cursor] + 8'd1;
                bfx_pkg::CH_DEC:   tape[cursor] = tape[cursor] - 8'd1;
                bfx_pkg::CH_IN:    tape[cursor] = arg;
                bfx_pkg::CH_OUT:
                begin
                    a.out_valid = 1'b1;
                    a.out_char  = tape[cursor];
                end
                bfx_pkg::CH_OPEN:
                begin
                    if (tape[cursor] == 8'd0)
                    begin
                        skipping  = 1'b1;
                        skip_nest = '0;
                    end
                    else if (loops_open >= LOOP_DEPTH)
                    begin
                        a.status = bfx_pkg::ST_OVERFLOW;
                        halted   = 1'b1;
                    end
                    else
                    begin
                        loop_heads[loops_open] =
                            bfx_pkg::POS_W'(((pos & POS_MASK) + 32'd1) & POS_MASK);
                        loops_open++;
                    end
                end
                bfx_pkg::CH_CLOSE:
                begin
                    if (loops_open == 0)
                    begin
                        a.status = bfx_pkg::ST_UNDERFLOW;
                        halted   = 1'b1;
                    end
                    else if (tape[cursor] == 8'd0)
                    begin
                        loops_open--;
                    end
                    else
                    begin
                        a.jump_valid  = 1'b1;
                        a.jump_target = loop_heads[loops_open - 1];
                    end
                end
                default: ;
            endcase
        end
        return a;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            foreach (tape[i])
                tape[i] = 8'h00;
            foreach (loop_heads[i])
                loop_heads[i] = '0;
            cursor     = 0;
            loops_open = 0;
            skipping   = 1'b0;
            skip_nest  = '0;
            halted     = 1'b0;
            due_answers.delete();
            fails = 0;
            backlog <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                due_answers.push_back(run_char(s_tdata[7:0], 32'(s_tdata[23:8]),
                                               s_tdata[31:24], s_tuser[0]));
            if (m_tvalid && m_tready)
            begin
                if (due_answers.size() == 0)
                begin
                    $error("result with no request pending: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    fails++;
                end
                else
                begin
                    want = due_answers.pop_front();
                    compare_field("out_valid", 32'(want.out_valid), 32'(m_tuser[0]));
                    compare_field("jump_valid", 32'(want.jump_valid), 32'(m_tuser[1]));
                    compare_field("out_char", 32'(want.out_char), 32'(m_tdata[7:0]));
                    compare_field("jump_target", 32'(want.jump_target),
                                  32'(m_tdata[23:8]));
                    compare_field("status", 32'(want.status), 32'(m_tdata[26:24]));
                    compare_field("zero fill", 32'd0, 32'(m_tdata[31:27]));
                end
            end
            backlog <= due_answers.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// testbench top: program stimulus, idling of both sides and the verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPE_CELLS   = 4096;
    localparam int LOOP_DEPTH   = 16;
    localparam int POS_BITS     = 16;
    localparam int RANDOM_ITEMS = 1100;
    localparam int NEST_RUN     = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 3_000_000;

    localparam logic [7:0] BODY_OPS [6] = '{bfx_pkg::CH_RIGHT, bfx_pkg::CH_LEFT,
                                            bfx_pkg::CH_INC, bfx_pkg::CH_DEC,
                                            bfx_pkg::CH_OUT, bfx_pkg::CH_IN};

    typedef enum {END_CLEAN, END_UNMATCHED, END_OVERFLOW, END_UNDERFLOW} finale_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [bfx_pkg::S_TDATA_W-1:0] s_tdata;
    logic [bfx_pkg::S_TUSER_W-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [bfx_pkg::M_TDATA_W-1:0] m_tdata;
    logic [bfx_pkg::M_TUSER_W-1:0] m_tuser;
    int                            fails;
    int                            backlog;

    // pacing state of the two sides
    bit quiet;
    bit random_on;
    bit hold_done;
    int unsigned calm_items;

    // what the program has done so far, as far as the stimulus needs to know
    logic [bfx_pkg::POS_W-1:0] fetch_pos;
    int unsigned               sent;
    int unsigned               stack_used;
    int unsigned               open_loops;
    int unsigned               skip_level;

    bf_instruction_executor_core #(
        .TAPE_CELLS (TAPE_CELLS),
        .LOOP_DEPTH (LOOP_DEPTH),
        .POS_BITS   (POS_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    bfx_result_checker #(
        .TAPE_CELLS (TAPE_CELLS),
        .LOOP_DEPTH (LOOP_DEPTH),
        .POS_BITS   (POS_BITS)
    ) result_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .fails    (fails),
        .backlog  (backlog)
    );

    always #10 clk = ~clk;

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm_items != 0)
        begin
            calm_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (quiet)
            return (r < 97) ? 0 : 1;
        if (r < 3)
        begin
            calm_items = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer(input logic [7:0] ch, input logic [7:0] arg, input bit eop);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {arg, fetch_pos, ch};
        s_tuser  <= eop;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        // now and then the fetch side resumes somewhere else
        if (random_on && $urandom_range(0, 31) == 0)
            fetch_pos = bfx_pkg::POS_W'($urandom);
        else
            fetch_pos = fetch_pos + 1'b1;
        gap = idle_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == bfx_pkg::CH_OPEN || b == bfx_pkg::CH_CLOSE);
        return b;
    endfunction

    // set the cell under the pointer so the next bracket takes a known branch
    task automatic bracket(input logic [7:0] ch, input bit nonzero);
        offer(bfx_pkg::CH_IN, nonzero ? 8'($urandom_range(1, 255)) : 8'd0, 1'b0);
        offer(ch, 8'($urandom), 1'b0);
    endtask

    task automatic leave_skip();
        while (skip_level != 0)
        begin
            offer(bfx_pkg::CH_CLOSE, 8'($urandom), 1'b0);
            skip_level--;
        end
    endtask

    task automatic program_step();
        int unsigned r;
        bit          taken;
        r = $urandom_range(0, 99);
        if (skip_level != 0)
        begin
            if (r < 12 && skip_level < 6)
            begin
                offer(bfx_pkg::CH_OPEN, 8'($urandom), 1'b0);
                skip_level++;
            end
            else if (r < 30)
            begin
                offer(bfx_pkg::CH_CLOSE, 8'($urandom), 1'b0);
                skip_level--;
            end
            else
            begin
                offer(noise_byte(), 8'($urandom), 1'b0);
            end
        end
        else if (r < 12)
        begin
            offer(noise_byte(), 8'($urandom), 1'b0);
        end
        else if (r < 60)
        begin
            offer(BODY_OPS[$urandom_range(0, 5)], 8'($urandom), 1'b0);
        end
        else if (r < 75)
        begin
            // a full stack only ever sees loops that are skipped
            taken = stack_used < LOOP_DEPTH && $urandom_range(0, 3) != 0;
            bracket(bfx_pkg::CH_OPEN, taken);
            if (taken)
            begin
                stack_used++;
                open_loops++;
            end
            else
            begin
                skip_level = 1;
            end
        end
        else if (r < 90 && open_loops != 0)
        begin
            taken = 1'($urandom_range(0, 1));
            bracket(bfx_pkg::CH_CLOSE, taken);
            open_loops--;
            if (!taken)
                stack_used--;
        end
        else if (r < 95 && stack_used > open_loops)
        begin
            // close bracket with no open bracket in the text; on a zero cell it eats a left-over entry
            taken = 1'($urandom_range(0, 1));
            bracket(bfx_pkg::CH_CLOSE, taken);
            if (!taken)
                stack_used--;
        end
        else if (open_loops != 0)
        begin
            // loop left open in the text, its entry stays on the stack
            open_loops--;
        end
        else
        begin
            offer(BODY_OPS[$urandom_range(0, 5)], 8'($urandom), 1'b0);
        end
    endtask

    // receiving side
    initial
    begin
        int unsigned run;
        int unsigned stall;
        int unsigned r;
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (random_on && !hold_done)
            begin
                // long hold-off while requests keep coming
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (quiet)
                run = $urandom_range(20, 60);
            else if (r < 5)
                run = $urandom_range(50, 150);
            else
                run = $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (quiet)
                stall = (r < 90) ? 0 : 1;
            else if (r < 45)
                stall = 0;
            else if (r < 90)
                stall = $urandom_range(1, 4);
            else
                stall = $urandom_range(10, 40);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // sending side and verdict
    initial
    begin
        bit      drained_once;
        finale_t finale;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        quiet      = 1'b0;
        random_on  = 1'b0;
        hold_done  = 1'b0;
        calm_items = 0;
        fetch_pos  = '0;
        sent       = 0;
        stack_used = 0;
        open_loops = 0;
        skip_level = 0;
        drained_once = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // pointer wrap both ways, cell wrap both ways, output of a cleared cell
        offer(bfx_pkg::CH_OUT, 8'h00, 1'b0);
        offer(bfx_pkg::CH_LEFT, 8'h00, 1'b0);
        offer(bfx_pkg::CH_DEC, 8'h00, 1'b0);
        offer(bfx_pkg::CH_OUT, 8'h00, 1'b0);
        offer(bfx_pkg::CH_RIGHT, 8'h00, 1'b0);
        offer(bfx_pkg::CH_IN, 8'hFF, 1'b0);
        offer(bfx_pkg::CH_INC, 8'h00, 1'b0);
        offer(bfx_pkg::CH_OUT, 8'h00, 1'b0);
        // skipped loop with a nested pair inside
        offer(bfx_pkg::CH_OPEN, 8'h00, 1'b0);
        offer(bfx_pkg::CH_OPEN, 8'h00, 1'b0);
        offer(bfx_pkg::CH_OUT, 8'h00, 1'b0);
        offer(bfx_pkg::CH_CLOSE, 8'h00, 1'b0);
        offer(bfx_pkg::CH_CLOSE, 8'h00, 1'b0);
        // loop opened at the last offset, jump target wraps to zero
        offer(bfx_pkg::CH_IN, 8'h01, 1'b0);
        fetch_pos = '1;
        offer(bfx_pkg::CH_OPEN, 8'h00, 1'b0);
        offer(bfx_pkg::CH_CLOSE, 8'h00, 1'b0);
        offer(bfx_pkg::CH_IN, 8'h00, 1'b0);
        offer(bfx_pkg::CH_CLOSE, 8'h00, 1'b0);
        offer(8'h00, 8'h00, 1'b0);
        offer(8'hFF, 8'hFF, 1'b0);
        offer(bfx_pkg::CH_IN, 8'h80, 1'b0);
        offer(bfx_pkg::CH_OUT, 8'h00, 1'b0);

        // deep nesting while skipped: the extra close ends the skip
        quiet = 1'b1;
        bracket(bfx_pkg::CH_OPEN, 1'b0);
        repeat (NEST_RUN) offer(bfx_pkg::CH_OPEN, 8'($urandom), 1'b0);
        repeat (NEST_RUN + 1) offer(bfx_pkg::CH_CLOSE, 8'($urandom), 1'b0);
        offer(bfx_pkg::CH_OUT, 8'($urandom), 1'b0);
        quiet = 1'b0;
        drain();

        random_on = 1'b1;
        sent      = 0;
        while (sent < RANDOM_ITEMS)
        begin
            program_step();
            if (!drained_once && sent >= RANDOM_ITEMS / 2)
            begin
                drain();
                drained_once = 1'b1;
            end
        end

        // only one way to halt per run, picked at random
        finale = finale_t'($urandom_range(0, 3));
        case (finale)
            END_CLEAN:
            begin
                leave_skip();
                offer(8'($urandom), 8'($urandom), 1'b1);
            end
            END_UNMATCHED:
            begin
                if (skip_level == 0)
                begin
                    bracket(bfx_pkg::CH_OPEN, 1'b0);
                    skip_level = 1;
                end
                offer(8'($urandom), 8'($urandom), 1'b1);
            end
            END_OVERFLOW:
            begin
                leave_skip();
                while (stack_used < LOOP_DEPTH)
                begin
                    bracket(bfx_pkg::CH_OPEN, 1'b1);
                    stack_used++;
                end
                bracket(bfx_pkg::CH_OPEN, 1'b1);
            end
            END_UNDERFLOW:
            begin
                leave_skip();
                while (stack_used != 0)
                begin
                    bracket(bfx_pkg::CH_CLOSE, 1'b0);
                    stack_used--;
                end
                bracket(bfx_pkg::CH_CLOSE, 1'($urandom_range(0, 1)));
            end
            default: ;
        endcase
        repeat (20) offer(8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);

        drain();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bfx_pkg.sv
hdl/bfx_ram.sv
hdl/bfx_front.sv
hdl/bfx_back.sv
hdl/bf_instruction_executor_core.sv
hdl/bfx_checker.sv
verif/bfx_result_checker.sv
verif/tb.sv
